/* rtl/frame_marked_tile_cache_defines.svh */
// Assertion macros used by the RTL of the tile cache.
`ifndef FRAME_MARKED_TILE_CACHE_DEFINES_SVH
`define FRAME_MARKED_TILE_CACHE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ftc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ftc_pkg;

    localparam int DEF_SLOTS      = 64;
    localparam int DEF_COORD_BITS = 20;

    localparam int FIELD_W  = 20;
    localparam int LEVEL_W  = 8;
    localparam int SLOT_W   = 6;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_FRAME  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FRAME   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STORED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [FIELD_W-1:0] tile_x;
        logic [FIELD_W-1:0] tile_y;
        logic [LEVEL_W-1:0] zoom_level;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                evicted;
        logic [FIELD_W-1:0]  evicted_x;
        logic [FIELD_W-1:0]  evicted_y;
        logic [LEVEL_W-1:0]  evicted_level;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/frame_marked_tile_cache.sv */
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      i_item   (ftc_pkg::t_in_item)
// result    out        o_strobe for one cycle    o_result (ftc_pkg::t_out_item)
//
// After reset the block clears its slot memory, one slot a cycle, from slot 0 up to the last slot.
// A begin-frame item reads every slot and writes it back with its in-use mark cleared.
// A lookup scans up from slot 0 and ends at the first hit, or at the last slot for a miss.
// An insert scans down from the last slot, takes the first slot not in use, and is dropped if none is free.
// An unused operation code is answered in the cycle after it is accepted.
// The result strobe lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

`include "frame_marked_tile_cache_defines.svh"

module frame_marked_tile_cache #(
    parameter int SLOTS      = ftc_pkg::DEF_SLOTS,
    parameter int COORD_BITS = ftc_pkg::DEF_COORD_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire ftc_pkg::t_in_item  i_item,
    output logic                    busy,
    output logic                    o_strobe,
    output ftc_pkg::t_out_item      o_result
);

    import ftc_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [LEVEL_W-1:0]    level;
    } t_tag;

    typedef struct packed {
        logic in_use;
        logic occupied;
        t_tag tag;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_FRAME  = 5'b00100,
        S_LOOKUP = 5'b01000,
        S_INSERT = 5'b10000
    } t_state;

    t_state    r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic      r_issue, n_issue;
    logic      r_rd_valid, n_rd_valid;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic      r_rd_last, n_rd_last;
    t_tag      r_req, n_req;
    logic      r_strobe, n_strobe;
    t_out_item r_result, n_result;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_q;
    t_entry        rd_data;
    logic          scanning;

    ftc_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_q)
    );

    assign rd_data  = t_entry'(rd_q);
    assign scanning = (r_state == S_FRAME) || (r_state == S_LOOKUP) || (r_state == S_INSERT);

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_issue    = r_issue;
        n_rd_valid = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_rd_last  = r_rd_last;
        n_req      = r_req;
        n_strobe   = 1'b0;
        n_result   = r_result;
        wr_en      = 1'b0;
        wr_addr    = r_rd_idx;
        wr_data    = rd_data;
        rd_en      = 1'b0;
        rd_addr    = r_addr;

        if (scanning && r_issue) begin
            rd_en      = 1'b1;
            n_rd_valid = 1'b1;
            n_rd_idx   = r_addr;
            if (r_state == S_INSERT) begin
                n_rd_last = (r_addr == '0);
                n_addr    = r_addr - 1'b1;
            end else begin
                n_rd_last = (r_addr == LAST_IDX);
                n_addr    = r_addr + 1'b1;
            end
            if (n_rd_last) begin
                n_issue = 1'b0;
                n_addr  = r_addr;
            end
        end

        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                wr_data = '0;
                if (r_addr == LAST_IDX) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req.x     = COORD_BITS'(i_item.tile_x);
                    n_req.y     = COORD_BITS'(i_item.tile_y);
                    n_req.level = i_item.zoom_level;
                    case (i_item.operation)
                        OP_FRAME: begin
                            n_state = S_FRAME;
                            n_addr  = '0;
                            n_issue = 1'b1;
                        end
                        OP_LOOKUP: begin
                            n_state = S_LOOKUP;
                            n_addr  = '0;
                            n_issue = 1'b1;
                        end
                        OP_INSERT: begin
                            n_state = S_INSERT;
                            n_addr  = LAST_IDX;
                            n_issue = 1'b1;
                        end
                        default: begin
                            n_strobe        = 1'b1;
                            n_result        = '0;
                            n_result.status = ST_MISS;
                        end
                    endcase
                end
            end
            S_FRAME: begin
                if (r_rd_valid) begin
                    wr_en          = 1'b1;
                    wr_data.in_use = 1'b0;
                    if (r_rd_last) begin
                        n_state         = S_IDLE;
                        n_issue         = 1'b0;
                        n_rd_valid      = 1'b0;
                        n_strobe        = 1'b1;
                        n_result        = '0;
                        n_result.status = ST_FRAME;
                    end
                end
            end
            S_LOOKUP: begin
                if (r_rd_valid) begin
                    if (rd_data.occupied && (rd_data.tag == r_req)) begin
                        wr_en           = 1'b1;
                        wr_data.in_use  = 1'b1;
                        n_state         = S_IDLE;
                        n_issue         = 1'b0;
                        n_rd_valid      = 1'b0;
                        n_strobe        = 1'b1;
                        n_result        = '0;
                        n_result.status = ST_HIT;
                        n_result.slot   = SLOT_W'(r_rd_idx);
                    end else if (r_rd_last) begin
                        n_state         = S_IDLE;
                        n_issue         = 1'b0;
                        n_rd_valid      = 1'b0;
                        n_strobe        = 1'b1;
                        n_result        = '0;
                        n_result.status = ST_MISS;
                    end
                end
            end
            S_INSERT: begin
                if (r_rd_valid) begin
                    if (!rd_data.in_use) begin
                        wr_en            = 1'b1;
                        wr_data.in_use   = 1'b1;
                        wr_data.occupied = 1'b1;
                        wr_data.tag      = r_req;
                        n_state          = S_IDLE;
                        n_issue          = 1'b0;
                        n_rd_valid       = 1'b0;
                        n_strobe         = 1'b1;
                        n_result         = '0;
                        n_result.status  = ST_STORED;
                        n_result.slot    = SLOT_W'(r_rd_idx);
                        if (rd_data.occupied) begin
                            n_result.evicted       = 1'b1;
                            n_result.evicted_x     = FIELD_W'(rd_data.tag.x);
                            n_result.evicted_y     = FIELD_W'(rd_data.tag.y);
                            n_result.evicted_level = rd_data.tag.level;
                        end
                    end else if (r_rd_last) begin
                        n_state         = S_IDLE;
                        n_issue         = 1'b0;
                        n_rd_valid      = 1'b0;
                        n_strobe        = 1'b1;
                        n_result        = '0;
                        n_result.status = ST_DROPPED;
                    end
                end
            end
            default: begin
                n_state    = S_CLEAR;
                n_addr     = '0;
                n_issue    = 1'b0;
                n_rd_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_addr     <= '0;
            r_issue    <= 1'b0;
            r_rd_valid <= 1'b0;
            r_rd_last  <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_issue    <= n_issue;
            r_rd_valid <= n_rd_valid;
            r_rd_last  <= n_rd_last;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_req    <= n_req;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `FTC_ASSERT_SAME(a_no_same_slot_overlap, i_clk, i_rst_n, wr_en && rd_en,
        wr_addr != rd_addr, "A slot is written and read in the same cycle.")
    `FTC_ASSERT_SAME(a_result_when_idle, i_clk, i_rst_n, o_strobe,
        r_state == S_IDLE, "A result item appeared while an item is still at work.")
    `FTC_ASSERT_SAME(a_read_data_follows_read, i_clk, i_rst_n, r_rd_valid,
        $past(rd_en), "Read data is used without a read in the previous cycle.")

endmodule

`default_nettype wire

/* rtl/ftc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ftc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
